[hw/rtl/segment_segment_distance_3d_defines.svh]
// Assertion macros for the segment distance block.
// Included by the modules that carry assertions; expects clk and arst_n in scope.
`ifndef SEGMENT_SEGMENT_DISTANCE_3D_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_3D_DEFINES_SVH

// same-cycle implication
`define SSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment distance: same-cycle check failed");

// next-cycle implication
`define SSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment distance: next-cycle check failed");

// fixed-delay implication
`define SSD_ASSERT_DLY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("segment distance: latency check failed");

`endif

[hw/rtl/ssd_pkg.sv]
// Shared constants and codes for the segment distance pipeline.
// No dependencies.
package ssd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int PARAM_FRAC_DEF  = 16;
	localparam int THRESH_W        = 40;
	localparam int DIST_W          = 42;
	localparam int DIST_FRAC       = 8;

	// divider lane mode: forced zero, forced one, or real quotient
	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_DIV  = 2'd2
	} div_mode_t;

endpackage

[hw/rtl/ssd_dots.sv]
// Front end: edge vectors (s1), component products (s2), dot products (s3).
// Depends on nothing but its parameters.
module ssd_dots #(
	parameter int CW = 16,
	localparam int DW = CW + 1,
	localparam int PW = 2 * DW,
	localparam int DOTW = PW + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [CW-1:0]   ps [3],
	input  logic signed [CW-1:0]   pe [3],
	input  logic signed [CW-1:0]   qs [3],
	input  logic signed [CW-1:0]   qe [3],
	output logic                   out_valid,
	output logic [9*DW-1:0]        geom,
	output logic signed [DOTW-1:0] a,
	output logic signed [DOTW-1:0] b,
	output logic signed [DOTW-1:0] c,
	output logic signed [DOTW-1:0] d,
	output logic signed [DOTW-1:0] e
);

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0] u_s1 [3], v_s1 [3], w_s1 [3];
	logic [9*DW-1:0]      geom_s2, geom_s3;
	logic signed [PW-1:0] uu_s2 [3], uv_s2 [3], vv_s2 [3], uw_s2 [3], vw_s2 [3];
	logic signed [DOTW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;
	logic [9*DW-1:0]      geom_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1: u = P1-P0, v = Q1-Q0, w = P0-Q0
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s1[i] <= DW'(pe[i]) - DW'(ps[i]);
			v_s1[i] <= DW'(qe[i]) - DW'(qs[i]);
			w_s1[i] <= DW'(ps[i]) - DW'(qs[i]);
		end
	end

	// pack vectors for the tag path
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geom_c[i*DW +: DW]     = u_s1[i];
			geom_c[(3+i)*DW +: DW] = v_s1[i];
			geom_c[(6+i)*DW +: DW] = w_s1[i];
		end
	end

	// s2: per-component products
	always_ff @(posedge clk) begin
		geom_s2 <= geom_c;
		for (int i = 0; i < 3; i++) begin
			uu_s2[i] <= PW'(u_s1[i]) * PW'(u_s1[i]);
			uv_s2[i] <= PW'(u_s1[i]) * PW'(v_s1[i]);
			vv_s2[i] <= PW'(v_s1[i]) * PW'(v_s1[i]);
			uw_s2[i] <= PW'(u_s1[i]) * PW'(w_s1[i]);
			vw_s2[i] <= PW'(v_s1[i]) * PW'(w_s1[i]);
		end
	end

	// s3: three-term sums
	always_ff @(posedge clk) begin
		geom_s3 <= geom_s2;
		a_s3 <= DOTW'(uu_s2[0]) + DOTW'(uu_s2[1]) + DOTW'(uu_s2[2]);
		b_s3 <= DOTW'(uv_s2[0]) + DOTW'(uv_s2[1]) + DOTW'(uv_s2[2]);
		c_s3 <= DOTW'(vv_s2[0]) + DOTW'(vv_s2[1]) + DOTW'(vv_s2[2]);
		d_s3 <= DOTW'(uw_s2[0]) + DOTW'(uw_s2[1]) + DOTW'(uw_s2[2]);
		e_s3 <= DOTW'(vw_s2[0]) + DOTW'(vw_s2[1]) + DOTW'(vw_s2[2]);
	end

	assign out_valid = vld_s3;
	assign geom      = geom_s3;
	assign a         = a_s3;
	assign b         = b_s3;
	assign c         = c_s3;
	assign d         = d_s3;
	assign e         = e_s3;

endmodule

[hw/rtl/ssd_solve.sv]
// Determinant, numerators and clamping of the closest-point fractions (s4..s7).
// Uses ssd_pkg for the threshold width.
module ssd_solve #(
	parameter int CW = 16,
	localparam int DW = CW + 1,
	localparam int DOTW = 2 * DW + 2,
	localparam int MW = 2 * DOTW,
	localparam int NW = MW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ssd_pkg::THRESH_W-1:0]  thresh,
	input  logic                          in_valid,
	input  logic [9*DW-1:0]               in_geom,
	input  logic signed [DOTW-1:0]        a,
	input  logic signed [DOTW-1:0]        b,
	input  logic signed [DOTW-1:0]        c,
	input  logic signed [DOTW-1:0]        d,
	input  logic signed [DOTW-1:0]        e,
	output logic                          out_valid,
	output logic [9*DW:0]                 out_tag,
	output logic signed [NW-1:0]          sn,
	output logic signed [NW-1:0]          sd,
	output logic signed [NW-1:0]          tn,
	output logic signed [NW-1:0]          td
);

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic [9*DW-1:0] geom_s4, geom_s5, geom_s6;

	logic signed [MW-1:0]   ac_s4, bb_s4, be_s4, cd_s4, ae_s4, bd_s4;
	logic signed [DOTW-1:0] a_s4, b_s4, c_s4, d_s4, e_s4;

	logic signed [NW-1:0]   dt_s5, sn_s5, tn_s5;
	logic signed [DOTW-1:0] a_s5, b_s5, c_s5, d_s5, e_s5;

	logic signed [NW-1:0]   dt_s6, sn_s6, tn_s6;
	logic signed [DOTW-1:0] a_s6, c_s6, e_s6;
	logic signed [DOTW:0]   eb_s6, nd0_s6, nd1_s6;
	logic par_s6, sneg_s6, sgt_s6, nd0neg_s6, nd0gt_s6, nd1neg_s6, nd1gt_s6;

	logic signed [NW-1:0] sn_s7, sd_s7, tn_s7, td_s7;
	logic [9*DW:0]        tag_s7;

	logic signed [DOTW:0] nd0_c, nd1_c;
	logic                 par_c;
	logic signed [NW-1:0] sn_m, sd_m, tn_m, td_m, sn_f, sd_f, tn_f;
	logic                 tneg, tgt, ndneg, ndgt;
	logic signed [DOTW:0] nd_m;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s4 <= in_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// s4: second-order products
	always_ff @(posedge clk) begin
		geom_s4 <= in_geom;
		ac_s4 <= MW'(a) * MW'(c);
		bb_s4 <= MW'(b) * MW'(b);
		be_s4 <= MW'(b) * MW'(e);
		cd_s4 <= MW'(c) * MW'(d);
		ae_s4 <= MW'(a) * MW'(e);
		bd_s4 <= MW'(b) * MW'(d);
		a_s4 <= a;
		b_s4 <= b;
		c_s4 <= c;
		d_s4 <= d;
		e_s4 <= e;
	end

	// s5: determinant and raw numerators
	always_ff @(posedge clk) begin
		geom_s5 <= geom_s4;
		dt_s5 <= NW'(ac_s4) - NW'(bb_s4);
		sn_s5 <= NW'(be_s4) - NW'(cd_s4);
		tn_s5 <= NW'(ae_s4) - NW'(bd_s4);
		a_s5 <= a_s4;
		b_s5 <= b_s4;
		c_s5 <= c_s4;
		d_s5 <= d_s4;
		e_s5 <= e_s4;
	end

	// s6 inputs: threshold test, re-solve numerators
	assign par_c = dt_s5[NW-1] ||
		(unsigned'(dt_s5) <= {{(NW-ssd_pkg::THRESH_W){1'b0}}, thresh});
	assign nd0_c = -(DOTW+1)'(d_s5);
	assign nd1_c = (DOTW+1)'(b_s5) - (DOTW+1)'(d_s5);

	// s6: branch flags
	always_ff @(posedge clk) begin
		geom_s6   <= geom_s5;
		dt_s6     <= dt_s5;
		sn_s6     <= sn_s5;
		tn_s6     <= tn_s5;
		a_s6      <= a_s5;
		c_s6      <= c_s5;
		e_s6      <= e_s5;
		eb_s6     <= (DOTW+1)'(e_s5) + (DOTW+1)'(b_s5);
		nd0_s6    <= nd0_c;
		nd1_s6    <= nd1_c;
		par_s6    <= par_c;
		sneg_s6   <= sn_s5[NW-1];
		sgt_s6    <= sn_s5 > dt_s5;
		nd0neg_s6 <= nd0_c[DOTW];
		nd0gt_s6  <= nd0_c > (DOTW+1)'(a_s5);
		nd1neg_s6 <= nd1_c[DOTW];
		nd1gt_s6  <= nd1_c > (DOTW+1)'(a_s5);
	end

	// s7 logic: clamp S, then T, then S again
	always_comb begin
		if (par_s6) begin
			sn_m = '0;
			sd_m = NW'(1);
			tn_m = NW'(e_s6);
			td_m = NW'(c_s6);
		end else if (sneg_s6) begin
			sn_m = '0;
			sd_m = dt_s6;
			tn_m = NW'(e_s6);
			td_m = NW'(c_s6);
		end else if (sgt_s6) begin
			sn_m = dt_s6;
			sd_m = dt_s6;
			tn_m = NW'(eb_s6);
			td_m = NW'(c_s6);
		end else begin
			sn_m = sn_s6;
			sd_m = dt_s6;
			tn_m = tn_s6;
			td_m = dt_s6;
		end
		tneg  = tn_m[NW-1];
		tgt   = tn_m > td_m;
		nd_m  = tneg ? nd0_s6 : nd1_s6;
		ndneg = tneg ? nd0neg_s6 : nd1neg_s6;
		ndgt  = tneg ? nd0gt_s6 : nd1gt_s6;
		sn_f  = sn_m;
		sd_f  = sd_m;
		tn_f  = tn_m;
		if (tneg || tgt) begin
			tn_f = tneg ? '0 : td_m;
			if (ndneg) begin
				sn_f = '0;
			end else if (ndgt) begin
				sn_f = sd_m;
			end else begin
				sn_f = NW'(nd_m);
				sd_f = NW'(a_s6);
			end
		end
	end

	// s7: final fractions
	always_ff @(posedge clk) begin
		sn_s7  <= sn_f;
		sd_s7  <= sd_f;
		tn_s7  <= tn_f;
		td_s7  <= td_m;
		tag_s7 <= {par_s6, geom_s6};
	end

	assign out_valid = vld_s7;
	assign out_tag   = tag_s7;
	assign sn        = sn_s7;
	assign sd        = sd_s7;
	assign tn        = tn_s7;
	assign td        = td_s7;

endmodule

[hw/rtl/ssd_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^F / den) saturated to 1.0; uses ssd_pkg lane modes.
module ssd_div #(
	parameter int NW = 73,
	parameter int F = 16,
	parameter int TW = 154
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [TW-1:0]        in_tag,
	input  logic signed [NW-1:0] num [2],
	input  logic signed [NW-1:0] den [2],
	output logic                 out_valid,
	output logic [TW-1:0]        out_tag,
	output logic [F:0]           quo [2]
);

	typedef struct packed {
		ssd_pkg::div_mode_t mode;
		logic [NW-2:0]      rem;
		logic [NW-2:0]      dvs;
		logic [F-1:0]       q;
	} lane_t;

	lane_t         lane_s [F+1][2];
	logic [F:0]    vld_s;
	logic [TW-1:0] tag_s [F+1];

	// valid chain through all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[F-1:0], in_valid};
		end
	end

	// entry stage: classify each lane
	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		for (int l = 0; l < 2; l++) begin
			lane_s[0][l].rem <= num[l][NW-2:0];
			lane_s[0][l].dvs <= den[l][NW-2:0];
			lane_s[0][l].q   <= '0;
			if (num[l][NW-1] || num[l] == '0 || den[l][NW-1] || den[l] == '0) begin
				lane_s[0][l].mode <= ssd_pkg::MODE_ZERO;
			end else if (num[l] >= den[l]) begin
				lane_s[0][l].mode <= ssd_pkg::MODE_ONE;
			end else begin
				lane_s[0][l].mode <= ssd_pkg::MODE_DIV;
			end
		end
	end

	// one compare-subtract per stage and lane
	for (genvar k = 0; k < F; k++) begin : g_step
		logic [NW-1:0] r2 [2];
		logic [NW-1:0] sub [2];
		logic          ge [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l]  = {lane_s[k][l].rem, 1'b0};
				sub[l] = r2[l] - {1'b0, lane_s[k][l].dvs};
				ge[l]  = r2[l] >= {1'b0, lane_s[k][l].dvs};
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			for (int l = 0; l < 2; l++) begin
				lane_s[k+1][l].mode <= lane_s[k][l].mode;
				lane_s[k+1][l].dvs  <= lane_s[k][l].dvs;
				lane_s[k+1][l].q    <= {lane_s[k][l].q[F-2:0], ge[l]};
				lane_s[k+1][l].rem  <= ge[l] ? sub[l][NW-2:0] : r2[l][NW-2:0];
			end
		end
	end

	// final selection
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			case (lane_s[F][l].mode)
				ssd_pkg::MODE_ONE: quo[l] = {1'b1, {F{1'b0}}};
				ssd_pkg::MODE_DIV: quo[l] = {1'b0, lane_s[F][l].q};
				default:           quo[l] = '0;
			endcase
		end
	end

	assign out_valid = vld_s[F];
	assign out_tag   = tag_s[F];

endmodule

[hw/rtl/ssd_dist.sv]
// Squared distance from the quantized parameters (d1..d4) and result registers.
// Uses ssd_pkg for the output width and fraction bits.
module ssd_dist #(
	parameter int CW = 16,
	parameter int F = 16,
	localparam int DW = CW + 1,
	localparam int TW = 9 * DW + 1,
	localparam int XW = DW + F + 2,
	localparam int SQW = 2 * XW,
	localparam int SUMW = (SQW + 2 > ssd_pkg::DIST_W) ? SQW + 2 : ssd_pkg::DIST_W + 1,
	localparam int SH = 2 * F - ssd_pkg::DIST_FRAC
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [TW-1:0]               in_tag,
	input  logic [F:0]                  sc,
	input  logic [F:0]                  tc,
	output logic                        out_valid,
	output logic [ssd_pkg::DIST_W-1:0]  sq_dist,
	output logic [F:0]                  sc_out,
	output logic [F:0]                  tc_out,
	output logic                        par
);

	logic vld_d1, vld_d2, vld_d3, vld_d4;
	logic signed [XW-1:0]  pu_d1 [3], pv_d1 [3], ws_d1 [3];
	logic signed [XW-1:0]  dx_d2 [3];
	logic signed [SQW-1:0] sq_d3 [3];
	logic [F:0]            sc_d1, sc_d2, sc_d3, sc_d4, tc_d1, tc_d2, tc_d3, tc_d4;
	logic                  par_d1, par_d2, par_d3, par_d4;
	logic [ssd_pkg::DIST_W-1:0] dist_d4;
	logic [SUMW-1:0]       sum_c, shr_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1 <= 1'b0;
			vld_d2 <= 1'b0;
			vld_d3 <= 1'b0;
			vld_d4 <= 1'b0;
		end else begin
			vld_d1 <= in_valid;
			vld_d2 <= vld_d1;
			vld_d3 <= vld_d2;
			vld_d4 <= vld_d3;
		end
	end

	// d1: sc*u, tc*v, w scaled to Q.F
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pu_d1[i] <= XW'($signed({1'b0, sc})) * XW'($signed(in_tag[i*DW +: DW]));
			pv_d1[i] <= XW'($signed({1'b0, tc})) * XW'($signed(in_tag[(3+i)*DW +: DW]));
			ws_d1[i] <= XW'($signed(in_tag[(6+i)*DW +: DW])) <<< F;
		end
		sc_d1  <= sc;
		tc_d1  <= tc;
		par_d1 <= in_tag[TW-1];
	end

	// d2: difference vector D
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dx_d2[i] <= ws_d1[i] + pu_d1[i] - pv_d1[i];
		end
		sc_d2  <= sc_d1;
		tc_d2  <= tc_d1;
		par_d2 <= par_d1;
	end

	// d3: squares
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_d3[i] <= SQW'(dx_d2[i]) * SQW'(dx_d2[i]);
		end
		sc_d3  <= sc_d2;
		tc_d3  <= tc_d2;
		par_d3 <= par_d2;
	end

	// sum, drop to 8 fraction bits, saturate
	assign sum_c = SUMW'(unsigned'(sq_d3[0])) + SUMW'(unsigned'(sq_d3[1]))
	             + SUMW'(unsigned'(sq_d3[2]));
	assign shr_c = sum_c >> SH;

	// d4: result registers
	always_ff @(posedge clk) begin
		if ((shr_c >> ssd_pkg::DIST_W) != '0) begin
			dist_d4 <= '1;
		end else begin
			dist_d4 <= shr_c[ssd_pkg::DIST_W-1:0];
		end
		sc_d4  <= sc_d3;
		tc_d4  <= tc_d3;
		par_d4 <= par_d3;
	end

	assign out_valid = vld_d4;
	assign sq_dist   = dist_d4;
	assign sc_out    = sc_d4;
	assign tc_out    = tc_d4;
	assign par       = par_d4;

endmodule

[hw/rtl/segment_segment_distance_3d.sv]
// Top level of the 3D segment-to-segment distance pipeline.
// Depends on ssd_pkg, ssd_dots, ssd_solve, ssd_div, ssd_dist and the defines header.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  item in   | start (busy = 0)   | first_/second_ start/end x,y,z
//  result    | done, one cycle    | squared_distance, first_param, second_param,
//            |                    | parallel_flag
//  config    | cfg_we             | cfg_wdata (parallel threshold)
//
// One beat enters every cycle; each result passes through ssd_dots, ssd_solve, the
// one-bit-per-stage divider chain and ssd_dist before done marks it.
// busy is always low: the pipeline never stalls and results cannot be held off.
// Reset clears the threshold and all valid bits; items in flight are dropped.
`include "segment_segment_distance_3d_defines.svh"

module segment_segment_distance_3d #(
	parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   first_start_x,
	input  logic signed [COORD_WIDTH-1:0]   first_start_y,
	input  logic signed [COORD_WIDTH-1:0]   first_start_z,
	input  logic signed [COORD_WIDTH-1:0]   first_end_x,
	input  logic signed [COORD_WIDTH-1:0]   first_end_y,
	input  logic signed [COORD_WIDTH-1:0]   first_end_z,
	input  logic signed [COORD_WIDTH-1:0]   second_start_x,
	input  logic signed [COORD_WIDTH-1:0]   second_start_y,
	input  logic signed [COORD_WIDTH-1:0]   second_start_z,
	input  logic signed [COORD_WIDTH-1:0]   second_end_x,
	input  logic signed [COORD_WIDTH-1:0]   second_end_y,
	input  logic signed [COORD_WIDTH-1:0]   second_end_z,
	input  logic                            cfg_we,
	input  logic [ssd_pkg::THRESH_W-1:0]    cfg_wdata,
	output logic                            done,
	output logic [ssd_pkg::DIST_W-1:0]      squared_distance,
	output logic [PARAM_FRAC_BITS:0]        first_param,
	output logic [PARAM_FRAC_BITS:0]        second_param,
	output logic                            parallel_flag
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int DOTW = 2 * DW + 2;
	localparam int NW   = 2 * DOTW + 1;
	localparam int TW   = 9 * DW + 1;
	localparam int LAT  = PARAM_FRAC_BITS + 12;

	logic [ssd_pkg::THRESH_W-1:0] thr_q;
	logic signed [COORD_WIDTH-1:0] ps [3], pe [3], qs [3], qe [3];

	logic                   dots_vld;
	logic [9*DW-1:0]        dots_geom;
	logic signed [DOTW-1:0] da, db, dc, dd, de;

	logic                 slv_vld;
	logic [TW-1:0]        slv_tag;
	logic signed [NW-1:0] slv_sn, slv_sd, slv_tn, slv_td;
	logic signed [NW-1:0] div_num [2], div_den [2];

	logic                     div_vld;
	logic [TW-1:0]            div_tag;
	logic [PARAM_FRAC_BITS:0] div_quo [2];

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	assign ps[0] = first_start_x;
	assign ps[1] = first_start_y;
	assign ps[2] = first_start_z;
	assign pe[0] = first_end_x;
	assign pe[1] = first_end_y;
	assign pe[2] = first_end_z;
	assign qs[0] = second_start_x;
	assign qs[1] = second_start_y;
	assign qs[2] = second_start_z;
	assign qe[0] = second_end_x;
	assign qe[1] = second_end_y;
	assign qe[2] = second_end_z;

	ssd_dots #(.CW(COORD_WIDTH)) u_dots (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.ps       (ps),
		.pe       (pe),
		.qs       (qs),
		.qe       (qe),
		.out_valid(dots_vld),
		.geom     (dots_geom),
		.a        (da),
		.b        (db),
		.c        (dc),
		.d        (dd),
		.e        (de)
	);

	ssd_solve #(.CW(COORD_WIDTH)) u_solve (
		.clk      (clk),
		.arst_n   (arst_n),
		.thresh   (thr_q),
		.in_valid (dots_vld),
		.in_geom  (dots_geom),
		.a        (da),
		.b        (db),
		.c        (dc),
		.d        (dd),
		.e        (de),
		.out_valid(slv_vld),
		.out_tag  (slv_tag),
		.sn       (slv_sn),
		.sd       (slv_sd),
		.tn       (slv_tn),
		.td       (slv_td)
	);

	assign div_num[0] = slv_sn;
	assign div_den[0] = slv_sd;
	assign div_num[1] = slv_tn;
	assign div_den[1] = slv_td;

	ssd_div #(.NW(NW), .F(PARAM_FRAC_BITS), .TW(TW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (slv_vld),
		.in_tag   (slv_tag),
		.num      (div_num),
		.den      (div_den),
		.out_valid(div_vld),
		.out_tag  (div_tag),
		.quo      (div_quo)
	);

	ssd_dist #(.CW(COORD_WIDTH), .F(PARAM_FRAC_BITS)) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_vld),
		.in_tag   (div_tag),
		.sc       (div_quo[0]),
		.tc       (div_quo[1]),
		.out_valid(done),
		.sq_dist  (squared_distance),
		.sc_out   (first_param),
		.tc_out   (second_param),
		.par      (parallel_flag)
	);

	// every accepted beat comes out after the fixed latency
	`SSD_ASSERT_DLY(a_latency, start && !busy, LAT, done)
	// parameters never exceed 1.0
	`SSD_ASSERT_IMP(a_sc_range, done, first_param <= {1'b1, {PARAM_FRAC_BITS{1'b0}}})
	`SSD_ASSERT_IMP(a_tc_range, done, second_param <= {1'b1, {PARAM_FRAC_BITS{1'b0}}})
	// a threshold write lands in the next cycle
	`SSD_ASSERT_NXT(a_cfg_write, cfg_we, thr_q == $past(cfg_wdata))

endmodule
